[sv/mts_pkg.sv]
// Shared types and constants for the one-shot melody tone sequencer.
// Holds command and register codes, the sequencer state type and the
// divider request/response structs; depends on nothing.
package mts_pkg;

  localparam int NOTES_DEF          = 64;
  localparam int TIMER_CLOCK_HZ_DEF = 1000000;

  // Shared divider widths: 32-bit dividend (tick count), 24-bit divisor
  // (duration times slow factor).
  localparam int DIV_W = 32;
  localparam int DVS_W = 24;
  localparam int VAL_W = 20;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_START = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_NOTE_COUNT     = 2'd0;
  localparam cfg_idx_t CFG_SLOW_FACTOR    = 2'd1;
  localparam cfg_idx_t CFG_VOLUME_DIVISOR = 2'd2;

  localparam logic [6:0] NOTE_COUNT_RST     = 7'd0;
  localparam logic [7:0] SLOW_FACTOR_RST    = 8'd1;
  localparam logic [7:0] VOLUME_DIVISOR_RST = 8'd50;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_RLD_WAIT,
    S_CMP_WAIT,
    S_PERIOD,
    S_MOD_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

[sv/one_shot_melody_tone_sequencer.sv]
// One-shot melody tone sequencer: top level with note table and sequencer.
// Depends on mts_pkg and the shared divider mts_div.
// A tone tick runs three divider passes in turn (reload, compare, modulo); a rest
// tick skips the first two, a zero note period skips the modulo, other items go
// straight to the result. One item at a time; the next is taken the cycle after
// the result is loaded, even while it waits. Reset (rst, synchronous): index,
// tick count, play flag, timer values and registers return to their defaults;
// the note table is not cleared.
module one_shot_melody_tone_sequencer #(
  parameter int NOTES          = mts_pkg::NOTES_DEF,
  parameter int TIMER_CLOCK_HZ = mts_pkg::TIMER_CLOCK_HZ_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_we,
  input  mts_pkg::cfg_idx_t           cfg_index,
  input  logic [7:0]                  cfg_data,
  // input item channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [5:0]                  entry_index,
  input  logic [15:0]                 note_freq,
  input  logic [15:0]                 note_duration,
  // result item channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mts_pkg::VAL_W-1:0]   reload_value,
  output logic [mts_pkg::VAL_W-1:0]   compare_value,
  output logic                        timer_updated,
  output logic                        playing
);

  localparam int DIV_W = mts_pkg::DIV_W;
  localparam int DVS_W = mts_pkg::DVS_W;
  localparam int VAL_W = mts_pkg::VAL_W;
  // Index must reach NOTES itself (one past the last note).
  localparam int IW    = $clog2(NOTES + 1);
  localparam int AW    = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  mts_pkg::state_t state, state_next;

  // configuration registers
  logic [6:0]       note_count;
  logic [7:0]       slow_factor;
  logic [7:0]       volume_divisor;

  // playback state
  logic [IW-1:0]    note_index;
  logic [31:0]      tick_count;
  logic             play_active;
  logic [VAL_W-1:0] reload_reg;
  logic [VAL_W-1:0] compare_reg;
  logic             updated;
  logic [DVS_W-1:0] period_reg;

  // note table: {freq, duration} per entry, registered read
  logic [31:0]      note_mem [NOTES];
  logic [15:0]      rd_freq;
  logic [15:0]      rd_dur;

  mts_pkg::div_req_t div_req;
  mts_pkg::div_rsp_t div_rsp;

  logic             accept;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [31:0]      count_cap;
  logic             at_end;
  logic             tick_go;
  logic [VAL_W-1:0] reload_sat;
  logic [7:0]       vol_eff;
  logic             out_free;

  mts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------
  always_comb begin
    accept   = in_valid && in_ready;
    wr_ok    = 32'(entry_index) < 32'(NOTES);
    wr_addr  = AW'(entry_index);
    rd_addr  = note_index[AW-1:0];
    // Limit the melody length to the table size.
    count_cap = (32'(note_count) > 32'(NOTES)) ? 32'(NOTES) : 32'(note_count);
    at_end   = 32'(note_index) >= count_cap;
    tick_go  = accept && (command == mts_pkg::CMD_TICK) && play_active && !at_end;
    // Saturate the reload to the timer width before deriving compare.
    reload_sat = (div_rsp.quotient > DIV_W'(VAL_MAX)) ? VAL_MAX
                                                      : div_rsp.quotient[VAL_W-1:0];
    vol_eff  = (volume_divisor == 8'd0) ? 8'd1 : volume_divisor;
    out_free = !out_valid || out_ready;
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      mts_pkg::S_IDLE: begin
        if (tick_go) begin
          state_next = mts_pkg::S_FETCH;
        end else if (accept) begin
          state_next = mts_pkg::S_EMIT;
        end
      end
      mts_pkg::S_FETCH: begin
        // a rest skips both timer divisions
        state_next = (rd_freq == 16'd0) ? mts_pkg::S_PERIOD : mts_pkg::S_RLD_WAIT;
      end
      mts_pkg::S_RLD_WAIT: begin
        if (div_rsp.done) state_next = mts_pkg::S_CMP_WAIT;
      end
      mts_pkg::S_CMP_WAIT: begin
        if (div_rsp.done) state_next = mts_pkg::S_PERIOD;
      end
      mts_pkg::S_PERIOD: begin
        // zero period advances every tick, no modulo needed
        state_next = (period_reg == '0) ? mts_pkg::S_EMIT : mts_pkg::S_MOD_WAIT;
      end
      mts_pkg::S_MOD_WAIT: begin
        if (div_rsp.done) state_next = mts_pkg::S_EMIT;
      end
      mts_pkg::S_EMIT: begin
        if (out_free) state_next = mts_pkg::S_IDLE;
      end
      default: state_next = mts_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (ready and divider requests)
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = tick_count;
    div_req.divisor  = period_reg;
    case (state)
      mts_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      mts_pkg::S_FETCH: begin
        // reload = timer clock / frequency
        div_req.start    = (rd_freq != 16'd0);
        div_req.dividend = DIV_W'(TIMER_CLOCK_HZ);
        div_req.divisor  = DVS_W'(rd_freq);
      end
      mts_pkg::S_RLD_WAIT: begin
        // compare = saturated reload / volume divisor, chained on done
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_W'(reload_sat);
        div_req.divisor  = DVS_W'(vol_eff);
      end
      mts_pkg::S_PERIOD: begin
        // tick count modulo period
        div_req.start = (period_reg != '0);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mts_pkg::S_IDLE;
      note_count     <= mts_pkg::NOTE_COUNT_RST;
      slow_factor    <= mts_pkg::SLOW_FACTOR_RST;
      volume_divisor <= mts_pkg::VOLUME_DIVISOR_RST;
      note_index     <= '0;
      tick_count     <= '0;
      play_active    <= 1'b0;
      reload_reg     <= '0;
      compare_reg    <= '0;
      updated        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          mts_pkg::CFG_NOTE_COUNT:     note_count     <= cfg_data[6:0];
          mts_pkg::CFG_SLOW_FACTOR:    slow_factor    <= cfg_data;
          mts_pkg::CFG_VOLUME_DIVISOR: volume_divisor <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        mts_pkg::S_IDLE: begin
          if (accept) begin
            updated <= 1'b0;
            case (command)
              mts_pkg::CMD_START: play_active <= 1'b1;
              mts_pkg::CMD_TICK: begin
                // past the last note: stop and rewind
                if (play_active && at_end) begin
                  play_active <= 1'b0;
                  note_index  <= '0;
                  tick_count  <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        mts_pkg::S_FETCH: begin
          // a rest silences the output and keeps the old reload
          if (rd_freq == 16'd0) compare_reg <= '0;
        end
        mts_pkg::S_RLD_WAIT: begin
          if (div_rsp.done) reload_reg <= reload_sat;
        end
        mts_pkg::S_CMP_WAIT: begin
          if (div_rsp.done) compare_reg <= div_rsp.quotient[VAL_W-1:0];
        end
        mts_pkg::S_PERIOD: begin
          if (period_reg == '0) begin
            note_index <= note_index + 1'b1;
            tick_count <= tick_count + 32'd1;
            updated    <= 1'b1;
          end
        end
        mts_pkg::S_MOD_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) note_index <= note_index + 1'b1;
            tick_count <= tick_count + 32'd1;
            updated    <= 1'b1;
          end
        end
        default: begin
        end
      endcase

      // output register: load on emit, drop once taken
      if (state == mts_pkg::S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == mts_pkg::S_FETCH) begin
      period_reg <= DVS_W'(rd_dur) * DVS_W'(slow_factor);
    end
    if (state == mts_pkg::S_EMIT && out_free) begin
      reload_value  <= reload_reg;
      compare_value <= compare_reg;
      timer_updated <= updated;
      playing       <= play_active;
    end
  end

  // Note table: written by write items, read at the current note index.
  always_ff @(posedge clk) begin
    if (accept && (command == mts_pkg::CMD_WRITE) && wr_ok) begin
      note_mem[wr_addr] <= {note_freq, note_duration};
    end
    {rd_freq, rd_dur} <= note_mem[rd_addr];
  end

endmodule

[sv/mts_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on mts_pkg for widths and the request/response structs.
module mts_div (
  input  logic              clk,
  input  logic              rst,
  input  mts_pkg::div_req_t req,
  output mts_pkg::div_rsp_t rsp
);

  localparam int DIV_W = mts_pkg::DIV_W;
  localparam int DVS_W = mts_pkg::DVS_W;
  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;

  // Partial remainder stays below the divisor, so the shifted value fits.
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[DVS_W]) begin
        rem <= trial[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

[sv/mts_checker.sv]
// Port-level checks for the one-shot melody tone sequencer.
// Depends on the top level's ports only; bound to it at the end of this file.
module mts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] reload_value,
  input logic [19:0] compare_value,
  input logic        timer_updated,
  input logic        playing
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reload_value)
      && $stable(compare_value) && $stable(timer_updated) && $stable(playing))
    else $error("result changed while stalled");

  // Drop ready right after each accepted item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // A tick that wrote the timers keeps playback running.
  a_updated_playing: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_updated |-> playing)
    else $error("timer update reported while stopped");

  // Compare never exceeds the reload it came from.
  a_compare_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_updated |-> compare_value <= reload_value)
    else $error("compare above reload");

endmodule

bind one_shot_melody_tone_sequencer mts_checker u_mts_checker (.*);
